### hw/rtl/tun_pkg.sv
// Shared constants, width helpers and the side-band struct of the triangle normal unit.
// No dependencies; every other file imports this package.
package tun_pkg;

    localparam int COORD_WIDTH_DEF      = 32;
    localparam int NORMAL_FRAC_BITS_DEF = 15;
    localparam int NUM_COMP             = 3;

    // Side-band carried next to the bit-search state of one triangle.
    typedef struct packed {
        logic [NUM_COMP-1:0] neg;
        logic                degen;
    } t_side;

    // Magnitude of one cross-product component.
    function automatic int mag_width(input int w);
        return 2 * w + 2;
    endfunction

    // Sum of the three squared components.
    function automatic int sum_width(input int w);
        return 2 * mag_width(w) + 2;
    endfunction

    // Signed residual and running product of the bit search.
    function automatic int res_width(input int w, input int f);
        return 2 * mag_width(w) + 2 * f + 8;
    endfunction

endpackage

### hw/rtl/tun_tri_if.sv
// Input channel of the triangle normal unit: valid, ready and three vertices.
// Depends on tun_pkg for the default coordinate width.
interface tun_tri_if import tun_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        output ready
    );
endinterface

### hw/rtl/tun_nrm_if.sv
// Output channel of the triangle normal unit: valid, ready, unit normal and flag.
// Depends on tun_pkg for the default fraction width.
interface tun_nrm_if import tun_pkg::*; #(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) ();
    logic                            valid;
    logic                            ready;
    logic signed [NORMAL_FRAC_BITS:0] normal_x;
    logic signed [NORMAL_FRAC_BITS:0] normal_y;
    logic signed [NORMAL_FRAC_BITS:0] normal_z;
    logic                            degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input  valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

### hw/rtl/tun_front.sv
// Front pipeline: edges, exact cross product, squared length and the start state
// of the bit search. Eight register stages. Depends on tun_pkg.
module tun_front import tun_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_vtx [9],
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [res_width(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] o_res [NUM_COMP],
    output logic signed [res_width(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] o_prd [NUM_COMP],
    output logic [sum_width(COORD_WIDTH)-1:0]   o_sum,
    output t_side                               o_side
);
    localparam int W     = COORD_WIDTH;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int EW    = W + 1;
    localparam int PW    = 2 * EW;
    localparam int CW    = PW + 1;
    localparam int MW    = mag_width(W);
    localparam int H     = MW / 2;
    localparam int SQW   = 2 * MW;
    localparam int SW    = sum_width(W);
    localparam int RW    = res_width(W, F);
    localparam int NSTG  = 8;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    logic signed [EW-1:0]  r_e   [6];
    logic signed [PW-1:0]  r_p   [6];
    logic signed [CW-1:0]  r_d   [NUM_COMP];
    logic [MW-1:0]         r_m   [NUM_COMP];
    logic [2*H-1:0]        r_hh  [NUM_COMP];
    logic [2*H-1:0]        r_hl  [NUM_COMP];
    logic [2*H-1:0]        r_ll  [NUM_COMP];
    logic [SQW-1:0]        r_sq  [NUM_COMP];
    logic [SQW-1:0]        r_sq7 [NUM_COMP];
    logic [SW-1:0]         r_s;
    logic signed [RW-1:0]  r_r   [NUM_COMP];
    logic signed [RW-1:0]  r_pr  [NUM_COMP];
    logic [SW-1:0]         r_s8;
    logic [NUM_COMP-1:0]   r_neg [NSTG];
    logic                  r_dg;

    // A stage moves when its register is empty or the next one takes its content.
    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Edges from the first vertex.
        if (en[0] && i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_e[i]   <= EW'(i_vtx[3+i]) - EW'(i_vtx[i]);
                r_e[3+i] <= EW'(i_vtx[6+i]) - EW'(i_vtx[i]);
            end
        end
        // Six exact products of the cross product, e1 = (0,1,2), e2 = (3,4,5).
        if (en[1] && r_v[0]) begin
            r_p[0] <= PW'(r_e[1]) * PW'(r_e[5]);
            r_p[1] <= PW'(r_e[2]) * PW'(r_e[4]);
            r_p[2] <= PW'(r_e[2]) * PW'(r_e[3]);
            r_p[3] <= PW'(r_e[0]) * PW'(r_e[5]);
            r_p[4] <= PW'(r_e[0]) * PW'(r_e[4]);
            r_p[5] <= PW'(r_e[1]) * PW'(r_e[3]);
        end
        if (en[2] && r_v[1]) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                r_d[c] <= CW'(r_p[2*c]) - CW'(r_p[2*c+1]);
            end
        end
        if (en[3] && r_v[2]) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                r_m[c]    <= r_d[c][CW-1] ? MW'(-r_d[c]) : MW'(r_d[c]);
                r_neg[3][c] <= r_d[c][CW-1];
            end
        end
        // Squares split into halves so each multiplier stays near 33 by 33 bits.
        if (en[4] && r_v[3]) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                r_hh[c] <= (2*H)'(r_m[c][MW-1:H]) * (2*H)'(r_m[c][MW-1:H]);
                r_hl[c] <= (2*H)'(r_m[c][MW-1:H]) * (2*H)'(r_m[c][H-1:0]);
                r_ll[c] <= (2*H)'(r_m[c][H-1:0]) * (2*H)'(r_m[c][H-1:0]);
            end
            r_neg[4] <= r_neg[3];
        end
        if (en[5] && r_v[4]) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                r_sq[c] <= (SQW'(r_hh[c]) << (2 * H)) + (SQW'(r_hl[c]) << (H + 1))
                         + SQW'(r_ll[c]);
            end
            r_neg[5] <= r_neg[4];
        end
        if (en[6] && r_v[5]) begin
            r_s      <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_sq7    <= r_sq;
            r_neg[6] <= r_neg[5];
        end
        // Start of the search: k = 0, so u = -1, residual 4*n^2*2^2F - S and u*S = -S.
        if (en[7] && r_v[6]) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                r_r[c]  <= signed'(RW'(r_sq7[c]) << (2 * F + 2)) - signed'(RW'(r_s));
                r_pr[c] <= -signed'(RW'(r_s));
            end
            r_s8     <= r_s;
            r_dg     <= (r_s == '0);
            r_neg[7] <= r_neg[6];
        end
    end

    assign o_res        = r_r;
    assign o_prd        = r_pr;
    assign o_sum        = r_s8;
    assign o_side.neg   = r_neg[7];
    assign o_side.degen = r_dg;

endmodule

### hw/rtl/tun_cell.sv
// One cell of the bit-search chain: decides bit BIT_POS of the rounded magnitude
// for all three components with shifts and adds only. Depends on tun_pkg.
module tun_cell import tun_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
    parameter int BIT_POS          = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [res_width(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] i_res [NUM_COMP],
    input  logic signed [res_width(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] i_prd [NUM_COMP],
    input  logic [sum_width(COORD_WIDTH)-1:0] i_sum,
    input  logic [NORMAL_FRAC_BITS:0]         i_k [NUM_COMP],
    input  t_side                             i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [res_width(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] o_res [NUM_COMP],
    output logic signed [res_width(COORD_WIDTH, NORMAL_FRAC_BITS)-1:0] o_prd [NUM_COMP],
    output logic [sum_width(COORD_WIDTH)-1:0] o_sum,
    output logic [NORMAL_FRAC_BITS:0]         o_k [NUM_COMP],
    output t_side                             o_side
);
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int SW = sum_width(COORD_WIDTH);
    localparam int RW = res_width(COORD_WIDTH, F);

    logic                 r_v;
    logic signed [RW-1:0] r_res [NUM_COMP];
    logic signed [RW-1:0] r_prd [NUM_COMP];
    logic [SW-1:0]        r_sum;
    logic [F:0]           r_k   [NUM_COMP];
    t_side                r_side;

    logic signed [RW-1:0] n_res [NUM_COMP];
    logic signed [RW-1:0] n_prd [NUM_COMP];
    logic [F:0]           n_k   [NUM_COMP];
    logic signed [RW-1:0] trial [NUM_COMP];
    logic signed [RW-1:0] s_sq;
    logic signed [RW-1:0] s_lin;

    // With u = 2k-1 and P = u*S, raising k by 2^j changes u^2*S by
    // P*2^(j+2) + S*2^(2j+2) and P by S*2^(j+1).
    always_comb begin
        s_sq  = signed'(RW'(i_sum) << (2 * BIT_POS + 2));
        s_lin = signed'(RW'(i_sum) << (BIT_POS + 1));
        for (int c = 0; c < NUM_COMP; c++) begin
            trial[c] = i_res[c] - (i_prd[c] <<< (BIT_POS + 2)) - s_sq;
            n_k[c]   = i_k[c];
            if (!trial[c][RW-1]) begin
                n_res[c]        = trial[c];
                n_prd[c]        = i_prd[c] + s_lin;
                n_k[c][BIT_POS] = 1'b1;
            end else begin
                n_res[c] = i_res[c];
                n_prd[c] = i_prd[c];
            end
        end
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res  <= n_res;
            r_prd  <= n_prd;
            r_k    <= n_k;
            r_sum  <= i_sum;
            r_side <= i_side;
        end
    end

    assign o_res  = r_res;
    assign o_prd  = r_prd;
    assign o_sum  = r_sum;
    assign o_k    = r_k;
    assign o_side = r_side;

endmodule

### hw/rtl/tun_fmt.sv
// Output register: saturates the magnitude, applies the sign and the degenerate
// case, and holds the result until it is taken. Depends on tun_pkg.
module tun_fmt import tun_pkg::*; #(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [NORMAL_FRAC_BITS:0]        i_k [NUM_COMP],
    input  t_side                            i_side,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [NORMAL_FRAC_BITS:0] o_nrm [NUM_COMP],
    output logic                             o_degen
);
    localparam int F = NORMAL_FRAC_BITS;

    logic              r_v;
    logic signed [F:0] r_nrm [NUM_COMP];
    logic              r_dg;
    logic signed [F:0] n_nrm [NUM_COMP];
    logic [F:0]        mag;

    always_comb begin
        mag = '0;
        for (int c = 0; c < NUM_COMP; c++) begin
            // A full-length component (1.0) does not fit and clips to the largest code.
            mag = i_k[c][F] ? {1'b0, {F{1'b1}}} : i_k[c];
            if (i_side.degen) begin
                n_nrm[c] = '0;
            end else if (i_side.neg[c]) begin
                n_nrm[c] = -signed'(mag);
            end else begin
                n_nrm[c] = signed'(mag);
            end
        end
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_nrm <= n_nrm;
            r_dg  <= i_side.degen;
        end
    end

    assign o_nrm   = r_nrm;
    assign o_degen = r_dg;

endmodule

### hw/rtl/triangle_unit_normal_unit.sv
// Triangle unit normal: an eight-stage front pipeline, then a chain of NORMAL_FRAC_BITS + 1
// search cells, one result bit each, and an output register. Throughput is one triangle
// per cycle while the output is not stalled.
// Every stage holds its content while the next is full, so stalls never drop data.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
module triangle_unit_normal_unit import tun_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tun_tri_if.sink   i_tri,
    tun_nrm_if.source o_nrm
);
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int SW    = sum_width(COORD_WIDTH);
    localparam int RW    = res_width(COORD_WIDTH, F);
    localparam int NCELL = F + 1;

    logic signed [COORD_WIDTH-1:0] vtx [9];

    logic                 c_v    [NCELL+1];
    logic                 c_rdy  [NCELL+1];
    logic signed [RW-1:0] c_res  [NCELL+1][NUM_COMP];
    logic signed [RW-1:0] c_prd  [NCELL+1][NUM_COMP];
    logic [SW-1:0]        c_sum  [NCELL+1];
    logic [F:0]           c_k    [NCELL+1][NUM_COMP];
    t_side                c_side [NCELL+1];
    logic signed [F:0]    nrm    [NUM_COMP];

    assign vtx[0] = i_tri.first_x;
    assign vtx[1] = i_tri.first_y;
    assign vtx[2] = i_tri.first_z;
    assign vtx[3] = i_tri.second_x;
    assign vtx[4] = i_tri.second_y;
    assign vtx[5] = i_tri.second_z;
    assign vtx[6] = i_tri.third_x;
    assign vtx[7] = i_tri.third_y;
    assign vtx[8] = i_tri.third_z;

    tun_front #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (F)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_tri.valid),
        .o_ready (i_tri.ready),
        .i_vtx   (vtx),
        .o_valid (c_v[0]),
        .i_ready (c_rdy[0]),
        .o_res   (c_res[0]),
        .o_prd   (c_prd[0]),
        .o_sum   (c_sum[0]),
        .o_side  (c_side[0])
    );

    assign c_k[0][0] = '0;
    assign c_k[0][1] = '0;
    assign c_k[0][2] = '0;

    // The cell at position g decides the bit of weight 2^(F-g), most significant first.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        tun_cell #(
            .COORD_WIDTH      (COORD_WIDTH),
            .NORMAL_FRAC_BITS (F),
            .BIT_POS          (F - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_v[g]),
            .o_ready (c_rdy[g]),
            .i_res   (c_res[g]),
            .i_prd   (c_prd[g]),
            .i_sum   (c_sum[g]),
            .i_k     (c_k[g]),
            .i_side  (c_side[g]),
            .o_valid (c_v[g+1]),
            .i_ready (c_rdy[g+1]),
            .o_res   (c_res[g+1]),
            .o_prd   (c_prd[g+1]),
            .o_sum   (c_sum[g+1]),
            .o_k     (c_k[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    tun_fmt #(
        .NORMAL_FRAC_BITS (F)
    ) u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_v[NCELL]),
        .o_ready (c_rdy[NCELL]),
        .i_k     (c_k[NCELL]),
        .i_side  (c_side[NCELL]),
        .o_valid (o_nrm.valid),
        .i_ready (o_nrm.ready),
        .o_nrm   (nrm),
        .o_degen (o_nrm.degenerate)
    );

    assign o_nrm.normal_x = nrm[0];
    assign o_nrm.normal_y = nrm[1];
    assign o_nrm.normal_z = nrm[2];

endmodule

### verif/tb_triangle_unit_normal_checker.sv
// Checker for the triangle normal unit: predicts the unit normal of every accepted
// triangle and compares each result transfer against the oldest prediction.
// Depends on tun_pkg and the channel interfaces tun_tri_if and tun_nrm_if.
module tb_triangle_unit_normal_checker import tun_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tun_tri_if    i_tri,
    tun_nrm_if    i_nrm,
    output int    o_fail,
    output int    o_pending,
    output int    o_results,
    output int    o_degen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               degen;
    } t_normal;

    t_normal normal_q[$];

    // Exact integer search for the rounded magnitude of each component.
    function automatic t_normal unit_normal(input logic [8:0][31:0] v);
        logic signed [33:0] e[6];
        logic signed [69:0] c[3];
        logic [255:0] m[3];
        logic [255:0] sq, rhs, lhs, d;
        int lo, hi, mid;
        logic [15:0] k[3];
        t_normal r;
        for (int i = 0; i < 6; i++) begin
            e[i] = $signed(v[i + 3]) - $signed(v[i % 3]);
        end
        c[0] = e[1] * e[5] - e[2] * e[4];
        c[1] = e[2] * e[3] - e[0] * e[5];
        c[2] = e[0] * e[4] - e[1] * e[3];
        for (int i = 0; i < 3; i++) begin
            m[i] = 256'(c[i] < 0 ? -c[i] : c[i]);
        end
        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        if (sq == 0) begin
            r = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, degen: 1'b1};
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            rhs = (m[i] * m[i]) << 32;
            lo = 0;
            hi = 32768;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                d = 256'(2 * mid - 1);
                lhs = d * d * sq;
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            if (lo > 32767) lo = 32767;
            k[i] = (c[i] < 0) ? -16'(lo) : 16'(lo);
        end
        r = '{x: k[0], y: k[1], z: k[2], degen: 1'b0};
        return r;
    endfunction

    assign o_pending = normal_q.size();

    always @(posedge i_clk) begin
        t_normal want;
        if (!i_rst_n) begin
            o_fail    <= 0;
            o_results <= 0;
            o_degen   <= 0;
        end else begin
            if (i_tri.valid && i_tri.ready) begin
                normal_q = {normal_q, unit_normal({i_tri.third_z, i_tri.third_y,
                    i_tri.third_x, i_tri.second_z, i_tri.second_y, i_tri.second_x,
                    i_tri.first_z, i_tri.first_y, i_tri.first_x})};
            end
            if (i_nrm.valid && i_nrm.ready) begin
                o_results <= o_results + 1;
                if (i_nrm.degenerate) o_degen <= o_degen + 1;
                if (normal_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: %h %h %h %b", $time,
                        i_nrm.normal_x, i_nrm.normal_y, i_nrm.normal_z, i_nrm.degenerate);
                    o_fail <= o_fail + 1;
                end else begin
                    want = normal_q.pop_front();
                    if (want.x !== i_nrm.normal_x || want.y !== i_nrm.normal_y ||
                        want.z !== i_nrm.normal_z || want.degen !== i_nrm.degenerate) begin
                        $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b",
                            $time, want.x, want.y, want.z, want.degen, i_nrm.normal_x,
                            i_nrm.normal_y, i_nrm.normal_z, i_nrm.degenerate);
                        o_fail <= o_fail + 1;
                    end
                end
            end
        end
    end
endmodule

### verif/tb_triangle_unit_normal_unit.sv
// Top of the triangle normal unit testbench: clock, reset, triangle stimulus with
// random gaps, random output stalls and the verdict. Depends on tun_pkg, the
// channel interfaces, the block and tb_triangle_unit_normal_checker.
module tb_triangle_unit_normal_unit import tun_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int NUM_RANDOM   = 1150;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   fail, pending, results, degen;
    bit   quiet = 1'b0;

    tun_tri_if #(.COORD_WIDTH(32)) tri_ch ();
    tun_nrm_if #(.NORMAL_FRAC_BITS(15)) nrm_ch ();

    triangle_unit_normal_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_ch),
        .o_nrm  (nrm_ch)
    );

    tb_triangle_unit_normal_checker u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tri    (tri_ch),
        .i_nrm    (nrm_ch),
        .o_fail   (fail),
        .o_pending(pending),
        .o_results(results),
        .o_degen  (degen)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        tri_ch.valid = 1'b0;
        {tri_ch.first_x, tri_ch.first_y, tri_ch.first_z} = '0;
        {tri_ch.second_x, tri_ch.second_y, tri_ch.second_z} = '0;
        {tri_ch.third_x, tri_ch.third_y, tri_ch.third_z} = '0;
        nrm_ch.ready = 1'b0;
    end

    // Output side: random stall before each result, none while quiet is set.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = quiet ? 0 : $urandom_range(9);
            if (n > 0) begin
                nrm_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            nrm_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!nrm_ch.valid);
        end
    end

    task automatic send_triangle(input logic [8:0][31:0] v);
        int n;
        n = quiet ? 0 : $urandom_range(9);
        if (n > 0) begin
            tri_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        tri_ch.valid    <= 1'b1;
        tri_ch.first_x  <= v[0];
        tri_ch.first_y  <= v[1];
        tri_ch.first_z  <= v[2];
        tri_ch.second_x <= v[3];
        tri_ch.second_y <= v[4];
        tri_ch.second_z <= v[5];
        tri_ch.third_x  <= v[6];
        tri_ch.third_y  <= v[7];
        tri_ch.third_z  <= v[8];
        do @(posedge i_clk); while (!tri_ch.ready);
    endtask

    function automatic logic [31:0] small_val();
        return 32'($signed($urandom_range(64)) - 32);
    endfunction

    // Mix of full-range, small-range, collinear, repeated-vertex, axis-aligned and coarse large-scale triangles.
    function automatic logic [8:0][31:0] random_triangle();
        logic [8:0][31:0] v;
        logic [31:0] s;
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++) v[i] = $urandom();
        case (kind)
            0, 1, 2, 3: ;
            4, 5: begin
                for (int i = 0; i < 9; i++) v[i] = small_val();
            end
            6: begin
                s = 32'($signed($urandom_range(6)) - 3);
                for (int i = 0; i < 3; i++) begin
                    v[i] = small_val() << 12;
                    v[i + 3] = v[i] + (small_val() << 8);
                    v[i + 6] = v[i] + s * (v[i + 3] - v[i]);
                end
            end
            7: begin
                for (int i = 3; i < 6; i++) v[i] = v[i - 3];
            end
            8: begin
                v[$urandom_range(2) + 3] = v[0] + small_val();
                v[1 + 3] = v[1]; v[2 + 3] = v[2];
                v[3] = v[0] + small_val();
                v[6] = v[0]; v[8] = v[2];
                v[7] = v[1] + small_val();
            end
            default: begin
                for (int i = 0; i < 9; i++) v[i] = small_val() << ($urandom_range(14) + 16);
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [8:0][31:0] d;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: degenerate cases, axis normals of full length, extremes.
        quiet = 1'b1;
        send_triangle('0);
        d = '0; d[3] = 32'd65536; d[7] = 32'd65536; send_triangle(d);
        d = '0; d[3] = 32'd65536; d[7] = -32'd65536; send_triangle(d);
        d = '0; d[4] = 32'd1; d[8] = 32'd1; send_triangle(d);
        d = '0; d[5] = 32'd1; d[6] = 32'd1; send_triangle(d);
        d = '0; d[4] = 32'd1; d[8] = -32'd1; send_triangle(d);
        d = '0; d[3] = 32'd1; d[4] = 32'd1; d[5] = 32'd1; d[6] = 32'd2;
        d[7] = 32'd2; d[8] = 32'd2; send_triangle(d);
        for (int i = 0; i < 9; i++) d[i] = 32'h7fffffff;
        send_triangle(d);
        for (int i = 0; i < 9; i++) d[i] = (i % 3 == i / 3) ? 32'h80000000 : 32'h7fffffff;
        send_triangle(d);
        for (int i = 0; i < 9; i++) d[i] = (i % 3 == i / 3) ? 32'h7fffffff : 32'h80000000;
        send_triangle(d);
        for (int i = 0; i < 9; i++) d[i] = (i < 3) ? 32'h80000000 : 32'h7fffffff;
        d[4] = 32'h80000000; d[8] = 32'h80000000; send_triangle(d);
        d = '0; d[3] = 32'd1; d[4] = 32'd1; d[6] = 32'd1; d[8] = 32'd1; send_triangle(d);
        d = '0; d[3] = 32'd3; d[7] = 32'd4; d[8] = 32'd12; send_triangle(d);
        d = '0; d[3] = 32'd1; d[7] = 32'd1; d[8] = 32'h7fffffff; send_triangle(d);
        quiet = 1'b0;

        for (int n = 0; n < NUM_RANDOM; n++) begin
            quiet = (n >= 300 && n < 400) || (n >= 800 && n < 850);
            if (n == 600) begin
                tri_ch.valid <= 1'b0;
                @(posedge i_clk iff pending == 0);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            send_triangle(random_triangle());
        end
        tri_ch.valid <= 1'b0;
        quiet = 1'b0;

        @(posedge i_clk iff pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d unit normals, %0d of them degenerate, under random gaps and stalls",
            results, degen);
        if (fail == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures, %0d results missing", fail, pending);
            $display("status: fail");
        end
        $finish;
    end
endmodule

### triangle_unit_normal_unit.f
hw/rtl/tun_pkg.sv
hw/rtl/tun_tri_if.sv
hw/rtl/tun_nrm_if.sv
hw/rtl/tun_front.sv
hw/rtl/tun_cell.sv
hw/rtl/tun_fmt.sv
hw/rtl/triangle_unit_normal_unit.sv
verif/tb_triangle_unit_normal_checker.sv
verif/tb_triangle_unit_normal_unit.sv
